// ----- hdl/gap_pkg.sv -----
// ----------------------------------------------------------------------------
// gap_pkg
// Shared types and constants of the global average pooling stream block.
// ----------------------------------------------------------------------------
package gap_pkg;

	localparam int DATA_W      = 64;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 11;
	localparam int MAP_W       = 11;
	localparam int ZVAL_W      = 7;
	localparam int SCALE_W     = 3;

	// reciprocal factor 2^25 / map + 1 needs 26 bits
	localparam int RECIP_SHIFT = 25;
	localparam int FACTOR_W    = RECIP_SHIFT + 1;
	localparam int DIV_STEPS   = RECIP_SHIFT + 1;

	// output shift: 25 + scale for positive codes, 17 + code for negative ones
	localparam logic [4:0] SHIFT_BASE     = 5'd25;
	localparam logic [4:0] SHIFT_NEG_BASE = 5'd17;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MODE_AVERAGE = 3'd0,
		REG_LOAD_WEIGHTS = 3'd1,
		REG_SCALE_SHIFT  = 3'd2,
		REG_MAP_SIZE     = 3'd3,
		REG_Z_VALUES     = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic                done;
		logic [FACTOR_W-1:0] factor;
	} recip_t;

endpackage

// ----- hdl/gap_recip.sv -----
// ----------------------------------------------------------------------------
// gap_recip
// Restoring divider producing the averaging factor 2^25 / map_size + 1,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gap_recip
	import gap_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [MAP_W-1:0] divisor,
	output recip_t           recip
);

	localparam int CNT_W = $clog2(DIV_STEPS);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    count_q;
	logic [MAP_W-1:0]    rem_q;
	logic [FACTOR_W-1:0] quo_q;
	logic [FACTOR_W-1:0] factor_q;

	logic                num_bit;
	logic [MAP_W:0]      rem_sh;
	logic                q_bit;
	logic [MAP_W:0]      rem_sub;

	// the dividend is a single one at its top bit
	assign num_bit = (count_q == CNT_W'(DIV_STEPS - 1));
	assign rem_sh  = {rem_q, num_bit};
	assign q_bit   = (rem_sh >= {1'b0, divisor});
	assign rem_sub = rem_sh - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				count_q <= CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				if (count_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					count_q <= count_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= q_bit ? rem_sub[MAP_W-1:0] : rem_sh[MAP_W-1:0];
			quo_q <= {quo_q[FACTOR_W-2:0], q_bit};
			if (count_q == '0)
				factor_q <= {quo_q[FACTOR_W-2:0], q_bit} + 1'b1;
		end
	end

	assign recip.done   = done_q;
	assign recip.factor = factor_q;

endmodule

// ----- hdl/global_average_pool_stream.sv -----
// ----------------------------------------------------------------------------
// global_average_pool_stream
// Streaming global average pooling over packed activation words.
// ----------------------------------------------------------------------------
// Items are handled one at a time. An echoed word (weight packets, or map
// words with pooling off) is accepted, then loaded into the output
// register once that is free. A pooled map word uses the sum memory port
// twice: read of the channel row on accept, add and write back in S_ACC.
// After the write-back of the last word of a frame the block waits while
// the divider makes the averaging factor one bit a cycle, then for each
// channel reads the row and runs each lane through the single multiplier
// and the saturating shift. A stalled output beat holds the block until
// it is taken. The sum memory is not cleared; the first position of a
// frame writes each row before any later position reads it.
// ----------------------------------------------------------------------------
module global_average_pool_stream
	import gap_pkg::*;
#(
	parameter int LANES        = 8,
	parameter int LANE_WIDTH   = 8,
	parameter int ACC_WIDTH    = 16,
	parameter int MAX_CHANNELS = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,

	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [DATA_W-1:0]      in_data,
	input  logic                   in_last,

	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [DATA_W-1:0]      out_data,
	output logic                   out_kind,
	output logic                   out_end
);

	localparam int WTOT   = LANES * LANE_WIDTH;
	localparam int EXT_W  = (WTOT > DATA_W) ? WTOT : DATA_W;
	localparam int ROW_W  = LANES * ACC_WIDTH;
	localparam int AW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CW     = $clog2(MAX_CHANNELS + 1);
	localparam int LIDX   = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int PROD_W = ACC_WIDTH + FACTOR_W;
	localparam logic [31:0] LANE_MAX = 32'((64'd1 << LANE_WIDTH) - 64'd1);

	typedef enum logic [1:0] {
		PH_START,
		PH_PKT1,
		PH_PKT2,
		PH_MAP
	} phase_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ECHO,
		S_ACC,
		S_DIV,
		S_DRD,
		S_DMUL,
		S_DSAT,
		S_DOUT
	} state_t;

	// configuration
	logic               mode_q;
	logic               load_q;
	logic [SCALE_W-1:0] scale_q;
	logic [MAP_W-1:0]   map_q;
	logic [ZVAL_W-1:0]  zval_q;

	// control
	state_t             state_q;
	phase_t             phase_q;
	logic [MAP_W-1:0]   pos_q;
	logic [CW-1:0]      chan_q;
	logic [AW-1:0]      ch_q;
	logic               first_q;
	logic               done_q;
	logic [AW-1:0]      drain_q;
	logic [LIDX-1:0]    lane_q;
	logic [DATA_W-1:0]  data_q;
	logic [EXT_W-1:0]   word_q;
	logic [31:0]        prod_s1;

	logic               out_valid_q;
	logic [DATA_W-1:0]  out_data_q;
	logic               out_kind_q;
	logic               out_end_q;

	// sum memory
	logic [ROW_W-1:0]   sums_mem [MAX_CHANNELS];
	logic [ROW_W-1:0]   rd_q;
	logic               mem_re;
	logic [AW-1:0]      mem_ra;
	logic               mem_we;
	logic [ROW_W-1:0]   acc_row;

	// effective limits
	logic [7:0]         z_raw;
	logic [7:0]         z_clip;
	logic [CW-1:0]      z_eff;
	logic [MAP_W-1:0]   ms_eff;

	// item bookkeeping
	logic               in_fire;
	phase_t             ph_eff;
	logic [CW-1:0]      ch_cur;
	logic [CW-1:0]      ch_inc;
	logic               ch_wrap;
	logic [MAP_W:0]     pos_nxt;
	logic               frame_done;

	// drain datapath
	logic               recip_start;
	recip_t             recip;
	logic [ACC_WIDTH-1:0] lane_sum;
	logic [PROD_W-1:0]  prod_full;
	logic [4:0]         shamt;
	logic [31:0]        shifted;
	logic [31:0]        sat_val;
	logic               out_free;
	logic               out_load;
	logic               drain_last;
	logic [EXT_W-1:0]   data_ext;

	assign z_raw  = (zval_q == '0) ? 8'd1 : {1'b0, zval_q};
	assign z_clip = (z_raw > 8'(MAX_CHANNELS)) ? 8'(MAX_CHANNELS) : z_raw;
	assign z_eff  = z_clip[CW-1:0];
	assign ms_eff = (map_q == '0) ? MAP_W'(1) : map_q;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign in_fire   = in_valid && !in_stall;

	always_comb begin
		ph_eff = phase_q;
		if (phase_q == PH_START)
			ph_eff = load_q ? PH_PKT1 : PH_MAP;
	end

	assign ch_cur     = (chan_q >= z_eff) ? (z_eff - 1'b1) : chan_q;
	assign ch_inc     = ch_cur + 1'b1;
	assign ch_wrap    = (ch_inc >= z_eff);
	assign pos_nxt    = {1'b0, pos_q} + (MAP_W + 1)'(ch_wrap);
	assign frame_done = (pos_nxt >= {1'b0, ms_eff});

	// add each lane of the new word to the stored row, or to zero at the first position
	assign data_ext = EXT_W'(data_q);
	for (genvar w = 0; w < LANES; w++) begin : g_lane
		logic [LANE_WIDTH-1:0] lane_in;
		assign lane_in = data_ext[(LANES-1-w)*LANE_WIDTH +: LANE_WIDTH];
		assign acc_row[w*ACC_WIDTH +: ACC_WIDTH] = ACC_WIDTH'(lane_in)
			+ (first_q ? ACC_WIDTH'(0) : rd_q[w*ACC_WIDTH +: ACC_WIDTH]);
	end

	assign mem_re = in_fire || (state_q == S_DRD);
	assign mem_ra = (state_q == S_DRD) ? drain_q : ch_cur[AW-1:0];
	assign mem_we = (state_q == S_ACC);

	always_ff @(posedge clk) begin
		if (mem_we)
			sums_mem[ch_q] <= acc_row;
		if (mem_re)
			rd_q <= sums_mem[mem_ra];
	end

	assign recip_start = (state_q == S_ACC) && done_q;

	gap_recip u_recip (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (recip_start),
		.divisor (ms_eff),
		.recip   (recip)
	);

	assign lane_sum  = rd_q[lane_q*ACC_WIDTH +: ACC_WIDTH];
	assign prod_full = PROD_W'(lane_sum) * PROD_W'(recip.factor);
	assign shamt     = scale_q[SCALE_W-1] ? ({2'b00, scale_q} + SHIFT_NEG_BASE)
	                                      : ({2'b00, scale_q} + SHIFT_BASE);
	assign shifted   = prod_s1 >> shamt;
	assign sat_val   = (shifted >= LANE_MAX) ? LANE_MAX : shifted;

	assign out_free   = !out_valid_q || !out_stall;
	assign out_load   = ((state_q == S_ECHO) || (state_q == S_DOUT)) && out_free;
	assign drain_last = ((CW'(drain_q) + 1'b1) == z_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			load_q      <= 1'b0;
			scale_q     <= '0;
			map_q       <= MAP_W'(1);
			zval_q      <= ZVAL_W'(1);
			state_q     <= S_IDLE;
			phase_q     <= PH_START;
			pos_q       <= '0;
			chan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_MODE_AVERAGE: mode_q  <= cfg_data[0];
					REG_LOAD_WEIGHTS: load_q  <= cfg_data[0];
					REG_SCALE_SHIFT:  scale_q <= cfg_data[SCALE_W-1:0];
					REG_MAP_SIZE:     map_q   <= cfg_data[MAP_W-1:0];
					REG_Z_VALUES:     zval_q  <= cfg_data[ZVAL_W-1:0];
					default: ;
				endcase
			end

			// drop a beat once taken, unless a new one loads
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						data_q <= in_data;
						if (ph_eff == PH_PKT1 || ph_eff == PH_PKT2) begin
							if (in_last)
								phase_q <= (ph_eff == PH_PKT1) ? PH_PKT2 : PH_MAP;
							else
								phase_q <= ph_eff;
							state_q <= S_ECHO;
						end else begin
							ch_q    <= ch_cur[AW-1:0];
							first_q <= (pos_q == '0);
							done_q  <= frame_done;
							if (frame_done) begin
								phase_q <= PH_START;
								pos_q   <= '0;
								chan_q  <= '0;
							end else begin
								phase_q <= PH_MAP;
								pos_q   <= pos_nxt[MAP_W-1:0];
								chan_q  <= ch_wrap ? '0 : ch_inc;
							end
							state_q <= mode_q ? S_ACC : S_ECHO;
						end
					end
				end
				S_ECHO: begin
					if (out_free) begin
						out_data_q  <= data_q;
						out_kind_q  <= 1'b0;
						out_end_q   <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_ACC: begin
					state_q <= done_q ? S_DIV : S_IDLE;
				end
				S_DIV: begin
					drain_q <= '0;
					if (recip.done)
						state_q <= S_DRD;
				end
				S_DRD: begin
					lane_q  <= '0;
					word_q  <= '0;
					state_q <= S_DMUL;
				end
				S_DMUL: begin
					prod_s1 <= prod_full[31:0];
					state_q <= S_DSAT;
				end
				S_DSAT: begin
					word_q[(LANES-1-int'(lane_q))*LANE_WIDTH +: LANE_WIDTH]
						<= LANE_WIDTH'(sat_val);
					if (lane_q == LIDX'(LANES - 1)) begin
						state_q <= S_DOUT;
					end else begin
						lane_q  <= lane_q + 1'b1;
						state_q <= S_DMUL;
					end
				end
				S_DOUT: begin
					if (out_free) begin
						out_data_q  <= word_q[DATA_W-1:0];
						out_kind_q  <= 1'b1;
						out_end_q   <= drain_last;
						// advance to the next channel row, or return to idle after the last
						if (drain_last) begin
							state_q <= S_IDLE;
						end else begin
							drain_q <= drain_q + 1'b1;
							state_q <= S_DRD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_kind  = out_kind_q;
	assign out_end   = out_end_q;

endmodule
